/* sv/assert_macros.svh */
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
		else $error("assertion failed");

`endif

/* sv/dpc_pkg.sv */
package dpc_pkg;

	localparam int FRAC_BITS = 16;

	localparam longint unsigned ONE_L = longint'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS-1:0] W_RED   = FRAC_BITS'((2126 * ONE_L + 5000) / 10000);
	localparam logic [FRAC_BITS-1:0] W_GREEN = FRAC_BITS'((7152 * ONE_L + 5000) / 10000);
	localparam logic [FRAC_BITS-1:0] W_BLUE  = FRAC_BITS'((724 * ONE_L + 5000) / 10000);

	localparam int PROD_W  = FRAC_BITS + 8;
	localparam int SUM_W   = FRAC_BITS + 9;
	localparam int RECIP_W = SUM_W - 7;
	localparam int RPROD_W = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((longint'(1) << SUM_W) + 254) / 255);
	localparam int LUMA_W  = FRAC_BITS + 1;
	localparam int MUL_W   = LUMA_W + 10;
	localparam int BLEND_W = FRAC_BITS + 12;

	localparam int PIPE_LAT = 7;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DARK_RED    = 3'd0,
		REG_DARK_GREEN  = 3'd1,
		REG_DARK_BLUE   = 3'd2,
		REG_LIGHT_RED   = 3'd3,
		REG_LIGHT_GREEN = 3'd4,
		REG_LIGHT_BLUE  = 3'd5
	} cfg_reg_t;

	localparam logic [7:0] KEY_RED   = 8'd1;
	localparam logic [7:0] KEY_GREEN = 8'd2;
	localparam logic [7:0] KEY_BLUE  = 8'd3;

	typedef struct packed {
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} result_t;

	typedef struct packed {
		logic              valid;
		logic              key;
		pixel_t            pix;
		logic [LUMA_W-1:0] q;
	} luma_t;

endpackage

/* sv/duotone_pixel_colorize.sv */
// Pipeline: luma stages s1 to s5, stage s6 and the result register lie between the start transfer and result_valid.
// Throughput: one pixel per cycle once busy is low after reset; fixed seven-stage pipeline, busy never stalls it.
// Reset: pipeline valid bits clear, dark color goes to 0, light color to 255;
// busy and cfg_ready stay in the reset state until the first clock after release.
// The receiver cannot stall: each result shows for exactly one cycle on result_valid.
module duotone_pixel_colorize (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  dpc_pkg::pixel_t                pixel,
	output logic                           result_valid,
	output dpc_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data
);
	import dpc_pkg::*;

	logic       ready_q;
	logic [7:0] dark_q  [3];
	logic [7:0] light_q [3];

	luma_t      luma;
	logic       valid_s6, key_s6;
	pixel_t     pix_s6;
	logic signed [MUL_W-1:0] prod_s6 [3];
	logic [7:0] chan_out [3];
	logic       result_valid_q;
	result_t    result_q;

	assign busy      = !ready_q;
	assign cfg_ready = ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q[0]  <= 8'd0;
			dark_q[1]  <= 8'd0;
			dark_q[2]  <= 8'd0;
			light_q[0] <= 8'd255;
			light_q[1] <= 8'd255;
			light_q[2] <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DARK_RED:    dark_q[0]  <= cfg_data;
				REG_DARK_GREEN:  dark_q[1]  <= cfg_data;
				REG_DARK_BLUE:   dark_q[2]  <= cfg_data;
				REG_LIGHT_RED:   light_q[0] <= cfg_data;
				REG_LIGHT_GREEN: light_q[1] <= cfg_data;
				REG_LIGHT_BLUE:  light_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	dpc_luma u_luma (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.in_pix   (pixel),
		.luma     (luma)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s6       <= luma.valid;
			result_valid_q <= valid_s6;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic signed [8:0]         diff;
		logic signed [MUL_W-1:0]   diff_x;
		logic signed [MUL_W-1:0]   q_x;
		logic signed [BLEND_W-1:0] dark_sc;
		logic signed [BLEND_W-1:0] blend;
		localparam logic signed [BLEND_W-1:0] LIMIT = BLEND_W'(255) << FRAC_BITS;

		assign diff    = signed'({1'b0, light_q[c]}) - signed'({1'b0, dark_q[c]});
		assign diff_x  = MUL_W'(diff);
		assign q_x     = signed'(MUL_W'({1'b0, luma.q}));
		assign dark_sc = signed'(BLEND_W'({dark_q[c], {FRAC_BITS{1'b0}}}));
		assign blend   = BLEND_W'(prod_s6[c]) + dark_sc;

		always_ff @(posedge clk) begin
			prod_s6[c] <= diff_x * q_x;
		end

		always_comb begin
			if (blend <= 0) begin
				chan_out[c] = 8'd0;
			end else if (blend >= LIMIT) begin
				chan_out[c] = 8'd255;
			end else begin
				chan_out[c] = blend[FRAC_BITS +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		key_s6 <= luma.key;
		pix_s6 <= luma.pix;
		if (key_s6) begin
			result_q.out_red   <= pix_s6.pixel_red;
			result_q.out_green <= pix_s6.pixel_green;
			result_q.out_blue  <= pix_s6.pixel_blue;
		end else begin
			result_q.out_red   <= chan_out[0];
			result_q.out_green <= chan_out[1];
			result_q.out_blue  <= chan_out[2];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* sv/dpc_luma.sv */
module dpc_luma (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  dpc_pkg::pixel_t in_pix,
	output dpc_pkg::luma_t  luma
);
	import dpc_pkg::*;

	logic               valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic               key_s1, key_s2, key_s3, key_s4, key_s5;
	pixel_t             pix_s1, pix_s2, pix_s3, pix_s4, pix_s5;
	logic [PROD_W-1:0]  pr_s1, pg_s1, pb_s1;
	logic [SUM_W-1:0]   sum_s2, sum_s3;
	logic [RPROD_W-1:0] rprod_s3;
	logic [LUMA_W-1:0]  luma_s4;
	logic [LUMA_W-1:0]  q_s5;

	logic               in_key;
	logic [LUMA_W-1:0]  est;
	logic [SUM_W-1:0]   est255;
	logic [2*LUMA_W-1:0] sq;

	assign in_key = (in_pix.pixel_red == KEY_RED) && (in_pix.pixel_green == KEY_GREEN) &&
		(in_pix.pixel_blue == KEY_BLUE);

	assign est    = rprod_s3[SUM_W +: LUMA_W];
	assign est255 = {est, 8'd0} - SUM_W'(est);
	assign sq     = luma_s4 * luma_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		key_s1 <= in_key;
		pix_s1 <= in_pix;
		pr_s1  <= PROD_W'(W_RED) * PROD_W'(in_pix.pixel_red);
		pg_s1  <= PROD_W'(W_GREEN) * PROD_W'(in_pix.pixel_green);
		pb_s1  <= PROD_W'(W_BLUE) * PROD_W'(in_pix.pixel_blue);

		key_s2 <= key_s1;
		pix_s2 <= pix_s1;
		sum_s2 <= SUM_W'(pr_s1) + SUM_W'(pg_s1) + SUM_W'(pb_s1);

		key_s3   <= key_s2;
		pix_s3   <= pix_s2;
		sum_s3   <= sum_s2;
		rprod_s3 <= RPROD_W'(sum_s2) * RPROD_W'(RECIP);

		key_s4  <= key_s3;
		pix_s4  <= pix_s3;
		luma_s4 <= (est255 > sum_s3) ? est - LUMA_W'(1) : est;

		key_s5 <= key_s4;
		pix_s5 <= pix_s4;
		q_s5   <= sq[FRAC_BITS +: LUMA_W];
	end

	assign luma.valid = valid_s5;
	assign luma.key   = key_s5;
	assign luma.pix   = pix_s5;
	assign luma.q     = q_s5;

endmodule

/* sv/dpc_checker.sv */
`include "assert_macros.svh"

module dpc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input dpc_pkg::pixel_t               pixel,
	input logic                          result_valid,
	input dpc_pkg::result_t              result,
	input logic                          cfg_ready
);
	import dpc_pkg::*;

	logic accept;
	logic key_in;
	logic key_out;

	assign accept = start && !busy;
	assign key_in = (pixel.pixel_red == KEY_RED) && (pixel.pixel_green == KEY_GREEN) &&
		(pixel.pixel_blue == KEY_BLUE);
	assign key_out = (result.out_red == KEY_RED) && (result.out_green == KEY_GREEN) &&
		(result.out_blue == KEY_BLUE);

	`ASSERT_IMPLY(a_result_follows, clk, arst_n, accept, ##PIPE_LAT result_valid)
	`ASSERT_IMPLY(a_no_spurious, clk, arst_n, result_valid, $past(accept, PIPE_LAT))
	`ASSERT_IMPLY(a_key_passes, clk, arst_n, accept && key_in, ##PIPE_LAT key_out)
	`ASSERT_NEXT(a_ready_pair, clk, arst_n, 1'b1, (busy != cfg_ready))

endmodule

bind duotone_pixel_colorize dpc_checker u_dpc_checker (.*);

/* sim/tb_duotone_pixel_colorize.sv */
`timescale 1ns / 1ps

module tb_duotone_pixel_colorize;

	import dpc_pkg::*;

	localparam int CLK_HALF = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PIXELS_PER_PHASE = 150;
	localparam int MAX_GAP = 14;

	class duotone_scoreboard;
		localparam longint ONE = longint'(1) << FRAC_BITS;
		localparam longint LUMA_WR = (2126 * ONE + 5000) / 10000;
		localparam longint LUMA_WG = (7152 * ONE + 5000) / 10000;
		localparam longint LUMA_WB = (724 * ONE + 5000) / 10000;

		result_t pending_colors[$];
		logic [7:0] dark[3];
		logic [7:0] light[3];
		int errors;
		int matched;

		function new();
			errors = 0;
			matched = 0;
			foreach (dark[i]) begin
				dark[i] = 8'd0;
				light[i] = 8'd255;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
			case (cfg_reg_t'(idx))
				REG_DARK_RED:    dark[0] = value;
				REG_DARK_GREEN:  dark[1] = value;
				REG_DARK_BLUE:   dark[2] = value;
				REG_LIGHT_RED:   light[0] = value;
				REG_LIGHT_GREEN: light[1] = value;
				REG_LIGHT_BLUE:  light[2] = value;
				default: ;
			endcase
		endfunction

		function logic [7:0] blend(logic [7:0] lt, logic [7:0] dk, longint q);
			longint s;
			s = longint'(lt) * q + longint'(dk) * (ONE - q);
			if (s <= 0)
				return 8'd0;
			if (s >= 255 * ONE)
				return 8'd255;
			return 8'(s >> FRAC_BITS);
		endfunction

		function result_t duotone_of(pixel_t p);
			longint luma;
			longint sq;
			result_t r;
			if (p.pixel_red == KEY_RED && p.pixel_green == KEY_GREEN &&
					p.pixel_blue == KEY_BLUE) begin
				r.out_red = p.pixel_red;
				r.out_green = p.pixel_green;
				r.out_blue = p.pixel_blue;
				return r;
			end
			luma = (LUMA_WR * longint'(p.pixel_red) + LUMA_WG * longint'(p.pixel_green) +
				LUMA_WB * longint'(p.pixel_blue)) / 255;
			sq = (luma * luma) >> FRAC_BITS;
			r.out_red = blend(light[0], dark[0], sq);
			r.out_green = blend(light[1], dark[1], sq);
			r.out_blue = blend(light[2], dark[2], sq);
			return r;
		endfunction

		function void note_pixel(pixel_t p);
			pending_colors.push_back(duotone_of(p));
		endfunction

		function int pending();
			return pending_colors.size();
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending_colors.size() == 0) begin
				report($sformatf("unexpected result %h", got));
				return;
			end
			want = pending_colors.pop_front();
			if (got.out_red !== want.out_red)
				report($sformatf("out_red %0d, want %0d", got.out_red, want.out_red));
			if (got.out_green !== want.out_green)
				report($sformatf("out_green %0d, want %0d", got.out_green, want.out_green));
			if (got.out_blue !== want.out_blue)
				report($sformatf("out_blue %0d, want %0d", got.out_blue, want.out_blue));
			matched++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	pixel_t pixel = '0;
	logic result_valid;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	duotone_scoreboard sb = new();
	int cycles = 0;
	int sent = 0;
	int key_sent = 0;
	int settings = 1;

	duotone_pixel_colorize dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(result);
	end

	task send_pixel(pixel_t p, int gap);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		pixel = p;
		do @(posedge clk); while (busy);
		sb.note_pixel(p);
		sent++;
		if (p.pixel_red == KEY_RED && p.pixel_green == KEY_GREEN && p.pixel_blue == KEY_BLUE)
			key_sent++;
	endtask

	task drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function pixel_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pixel_t p;
		p.pixel_red = r;
		p.pixel_green = g;
		p.pixel_blue = b;
		return p;
	endfunction

	function pixel_t random_pixel();
		pixel_t key;
		key = make_pixel(KEY_RED, KEY_GREEN, KEY_BLUE);
		case ($urandom_range(0, 9))
			0: return key;
			1: return key ^ (24'd1 << $urandom_range(0, 23));
			2: return make_pixel(8'($urandom_range(235, 255)), 8'($urandom_range(235, 255)),
				8'($urandom_range(235, 255)));
			3: return make_pixel(8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
				8'($urandom_range(0, 8)));
			default: return pixel_t'($urandom);
		endcase
	endfunction

	function logic [7:0] random_color();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	pixel_t base_pixels[$];
	pixel_t flip_pixels[$];

	initial begin
		base_pixels = '{
			make_pixel(8'd0, 8'd0, 8'd0),
			make_pixel(8'd255, 8'd255, 8'd255),
			make_pixel(KEY_RED, KEY_GREEN, KEY_BLUE),
			make_pixel(KEY_RED, KEY_GREEN, KEY_BLUE + 8'd1),
			make_pixel(KEY_RED - 8'd1, KEY_GREEN, KEY_BLUE),
			make_pixel(KEY_RED, KEY_GREEN + 8'd1, KEY_BLUE),
			make_pixel(8'd255, 8'd0, 8'd0),
			make_pixel(8'd0, 8'd255, 8'd0),
			make_pixel(8'd0, 8'd0, 8'd255),
			make_pixel(8'd128, 8'd128, 8'd128),
			make_pixel(8'd250, 8'd252, 8'd255),
			make_pixel(8'd170, 8'd85, 8'd170)
		};
		flip_pixels = '{
			make_pixel(8'd0, 8'd0, 8'd0),
			make_pixel(8'd255, 8'd255, 8'd255),
			make_pixel(KEY_RED, KEY_GREEN, KEY_BLUE),
			make_pixel(8'd254, 8'd255, 8'd255),
			make_pixel(8'd64, 8'd192, 8'd32),
			make_pixel(8'd1, 8'd1, 8'd1),
			make_pixel(8'd255, 8'd255, 8'd0),
			make_pixel(8'd200, 8'd180, 8'd220)
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (base_pixels[i])
			send_pixel(base_pixels[i], (i % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP));
		drain();

		for (int i = 0; i < 3; i++) begin
			write_reg(cfg_reg_t'(int'(REG_DARK_RED) + i), 8'd255);
			write_reg(cfg_reg_t'(int'(REG_LIGHT_RED) + i), 8'd0);
		end
		settings++;
		foreach (flip_pixels[i])
			send_pixel(flip_pixels[i], $urandom_range(0, 2));
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			int burst;
			for (int r = 0; r < 6; r++)
				write_reg(cfg_reg_t'(int'(REG_DARK_RED) + r), random_color());
			if ($urandom_range(0, 1))
				write_reg(CFG_IDX_W'($urandom_range(int'(REG_LIGHT_BLUE) + 1,
					(1 << CFG_IDX_W) - 1)), 8'($urandom));
			settings++;
			burst = $urandom_range(0, 2) == 0;
			for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
				int gap;
				if (burst || $urandom_range(0, 2) == 0)
					gap = 0;
				else
					gap = $urandom_range(0, MAX_GAP);
				send_pixel(random_pixel(), gap);
			end
			drain();
		end

		repeat (PIPE_LAT + 4) @(posedge clk);

		$display("Sent %0d pixels (%0d key color) across %0d color settings,", sent, key_sent,
			settings);
		$display("%0d results compared, %0d mismatches.", sb.matched, sb.errors);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
